>>> design/lsp_pkg.sv
`default_nettype none

package lsp_pkg;

    // stored sample format
    localparam int MAX_FRAMES  = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int CHANNELS    = 2;

    // derived widths
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int FRAME_W    = 17;
    localparam int POS_W      = 1 + FRAME_W + FRAC_BITS;
    localparam int RATE_W     = 24;
    localparam int RAM_W      = SAMPLE_BITS * CHANNELS;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = ADDR_W + RAM_W;
    localparam int OUT_DATA_W = RAM_W;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // modulo unit widths
    localparam int MOD_X_W = POS_W + 1;
    localparam int MOD_D_W = POS_W;

    localparam logic [FRAME_W-1:0] MAX_LEN = FRAME_W'(MAX_FRAMES);

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_START  = 2'd1,
        KIND_RENDER = 2'd2,
        KIND_STOP   = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd4;

    // status bits in the result tuser
    localparam int USER_ACTIVE = 0;
    localparam int USER_DONE   = 1;

endpackage

`default_nettype wire

>>> design/lsp_ram.sv
`default_nettype none

module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> design/lsp_lane.sv
`default_nettype none

module lsp_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [lsp_pkg::SAMPLE_BITS-1:0] i_s0,
    input  wire logic signed [lsp_pkg::SAMPLE_BITS-1:0] i_s1,
    input  wire logic        [lsp_pkg::FRAC_BITS-1:0]   i_frac,
    output logic signed      [lsp_pkg::SAMPLE_BITS-1:0] o_res
);
    import lsp_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [FRAC_BITS:0]   w_frac;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SAMPLE_BITS-1:0] r_s0;
    logic signed [PROD_W-1:0]    w_rnd;
    logic signed [PROD_W-1:0]    w_sum;

    // slope times fraction, registered
    assign w_diff = DIFF_W'(i_s1) - DIFF_W'(i_s0);
    assign w_frac = $signed({1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_diff * w_frac;
            r_s0   <= i_s0;
        end
    end

    // round half up, floor shift, add base sample
    assign w_rnd = r_prod + HALF;
    assign w_sum = PROD_W'(r_s0) + (w_rnd >>> FRAC_BITS);
    assign o_res = w_sum[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

>>> design/lsp_mod.sv
`default_nettype none

module lsp_mod (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [lsp_pkg::MOD_X_W-1:0] i_x,
    input  wire logic        [lsp_pkg::MOD_D_W-1:0] i_d,
    output logic                                    o_done,
    output logic             [lsp_pkg::MOD_D_W-1:0] o_rem
);
    import lsp_pkg::*;

    localparam int CNT_W = $clog2(MOD_X_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MOD_X_W - 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [MOD_X_W-1:0] r_mag;
    logic               r_neg;
    logic [MOD_D_W-1:0] r_d;
    logic [MOD_D_W-1:0] r_rem;
    logic [MOD_D_W:0]   w_trial;
    logic [MOD_D_W:0]   w_diff;

    // one restoring step per cycle
    assign w_trial = {r_rem, r_mag[MOD_X_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses after the last remainder bit
            o_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_x[MOD_X_W-1];
                r_mag  <= i_x[MOD_X_W-1] ? MOD_X_W'(-i_x) : MOD_X_W'(i_x);
                r_d    <= i_d;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_mag <= r_mag << 1;
                r_rem <= w_diff[MOD_D_W] ? w_trial[MOD_D_W-1:0] : w_diff[MOD_D_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // true modulo: negative dividend folds back into range
    assign o_rem = (r_neg && (r_rem != '0)) ? (r_d - r_rem) : r_rem;

endmodule

`default_nettype wire

>>> design/looping_sample_player_interp.sv
`default_nettype none
// channel   | direction | handshake                  | payload
// s stream  | in        | i_s_tvalid / o_s_tready    | tdata address, ch0, ch1; tuser kind
// m stream  | out       | o_m_tvalid / i_m_tready    | tdata out_ch0, out_ch1; tuser active, done
// cfg write | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// load, start and stop complete in the idle state; a silent render goes straight
// to the output register, an audible one passes through two reads of the single-port
// sample memory, one multiply stage and one rounding stage per channel lane.
// a looping render whose position lies outside the play region adds one modulo
// pass (one remainder bit per cycle). reset is synchronous, active low, and
// clears position, play flags and registers; the sample memory is not cleared.
// the output register lets the next item enter while a result waits; a render
// whose result meets a full output register waits there for the sink.

module looping_sample_player_interp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // address [15:0], sample_ch0 [31:16], sample_ch1 [47:32]
    input  wire logic [lsp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // kind [1:0]
    input  wire logic [lsp_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // out_ch0 [15:0], out_ch1 [31:16]
    output logic      [lsp_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // active [0], done_res [1]
    output logic      [lsp_pkg::OUT_USER_W-1:0]   o_m_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_MOD, S_RD0, S_RD1, S_MUL, S_FIN, S_OUT
    } t_state;

    localparam logic signed [RATE_W-1:0] RATE_ONE = RATE_W'(1) <<< FRAC_BITS;

    // configuration registers
    logic [FRAME_W-1:0]        r_buf_len;
    logic                      r_loop_en;
    logic [FRAME_W-1:0]        r_loop_start;
    logic [FRAME_W-1:0]        r_loop_end;
    logic signed [RATE_W-1:0]  r_rate;

    // playback state
    t_state                    r_state;
    logic signed [POS_W-1:0]   r_pos;
    logic                      r_playing;
    logic                      r_finished;
    logic [FRAME_W-1:0]        r_start;
    logic [FRAME_W-1:0]        r_end;
    logic [ADDR_W-1:0]         r_nxt;
    logic [RAM_W-1:0]          r_s0w;
    logic [RAM_W-1:0]          r_res;

    // output register
    logic                      r_m_valid;
    logic [OUT_DATA_W-1:0]     r_m_data;
    logic [OUT_USER_W-1:0]     r_m_user;

    logic                      w_accept;
    t_kind                     w_kind;
    logic [FRAME_W-1:0]        w_len;
    logic [FRAME_W-1:0]        w_le_clip;
    logic                      w_use_loop;
    logic [FRAME_W-1:0]        w_start;
    logic [FRAME_W-1:0]        w_end;
    logic                      w_silent;
    logic                      w_unit;
    logic signed [POS_W-1:0]   w_ps;
    logic signed [POS_W-1:0]   w_pe;
    logic [POS_W-1:0]          w_d;
    logic                      w_inside;
    logic [ADDR_W-1:0]         w_idx;
    logic [FRAME_W-1:0]        w_idx1;
    logic [ADDR_W-1:0]         w_nxt;
    logic signed [MOD_X_W-1:0] w_mod_x;
    logic                      w_mod_start;
    logic                      w_mod_done;
    logic [MOD_D_W-1:0]        w_mod_rem;
    logic                      w_ram_we;
    logic [ADDR_W-1:0]         w_ram_addr;
    logic [RAM_W-1:0]          w_ram_rdata;
    logic [RAM_W-1:0]          w_lane_res;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_user;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_kind   = t_kind'(i_s_tuser);

    // play region from the registers
    assign w_len      = (r_buf_len > MAX_LEN) ? MAX_LEN : r_buf_len;
    assign w_le_clip  = (r_loop_end < w_len) ? r_loop_end : w_len;
    assign w_use_loop = r_loop_en && (r_loop_start < r_loop_end) && (r_loop_start < w_le_clip);
    assign w_start    = w_use_loop ? r_loop_start : '0;
    assign w_end      = w_use_loop ? w_le_clip : w_len;
    assign w_silent   = !r_playing || (w_len == '0) || (r_rate == '0);
    assign w_unit     = (r_rate == RATE_ONE) || (r_rate == -RATE_ONE);

    // region edges in position units
    assign w_ps     = $signed({1'b0, r_start, {FRAC_BITS{1'b0}}});
    assign w_pe     = $signed({1'b0, r_end, {FRAC_BITS{1'b0}}});
    assign w_d      = POS_W'(w_pe - w_ps);
    assign w_inside = (r_pos >= w_ps) && (r_pos < w_pe);

    // frame under the position and the one after it
    assign w_idx  = r_pos[FRAC_BITS +: ADDR_W];
    assign w_idx1 = {1'b0, w_idx} + 1'b1;
    assign w_nxt  = (w_idx1 >= r_end) ? (r_loop_en ? r_start[ADDR_W-1:0] : w_idx)
                                      : w_idx1[ADDR_W-1:0];

    // wrap of an out-of-region position
    assign w_mod_x     = MOD_X_W'(r_pos) - MOD_X_W'(w_ps);
    assign w_mod_start = (r_state == S_CHK) && !w_inside && r_loop_en;

    lsp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_x     (w_mod_x),
        .i_d     (w_d),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // sample memory address select
    assign w_ram_we = w_accept && (w_kind == KIND_LOAD);

    always_comb begin
        case (r_state)
            S_RD0:   w_ram_addr = w_idx;
            S_RD1:   w_ram_addr = r_nxt;
            default: w_ram_addr = i_s_tdata[ADDR_W-1:0];
        endcase
    end

    lsp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_s_tdata[ADDR_W +: RAM_W]),
        .o_rdata (w_ram_rdata)
    );

    // one interpolation lane per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        lsp_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (r_state == S_MUL),
            .i_s0   (r_s0w[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_s1   (w_ram_rdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_frac (r_pos[FRAC_BITS-1:0]),
            .o_res  (w_lane_res[g*SAMPLE_BITS +: SAMPLE_BITS])
        );
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len    <= '0;
            r_loop_en    <= 1'b0;
            r_loop_start <= '0;
            r_loop_end   <= '0;
            r_rate       <= RATE_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BUF_LEN:    r_buf_len    <= i_cfg_data[FRAME_W-1:0];
                CFG_LOOP_EN:    r_loop_en    <= i_cfg_data[0];
                CFG_LOOP_START: r_loop_start <= i_cfg_data[FRAME_W-1:0];
                CFG_LOOP_END:   r_loop_end   <= i_cfg_data[FRAME_W-1:0];
                CFG_RATE:       r_rate       <= $signed(i_cfg_data[RATE_W-1:0]);
                default: ;
            endcase
        end
    end

    // item sequencer, playback state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_playing  <= 1'b0;
            r_finished <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            // sink takes the result; a new one loads in S_OUT below
            if (r_m_valid && i_m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_kind)
                            KIND_START: begin
                                r_pos      <= '0;
                                r_playing  <= 1'b1;
                                r_finished <= 1'b0;
                            end
                            KIND_STOP: begin
                                r_playing <= 1'b0;
                            end
                            KIND_RENDER: begin
                                if (w_silent) begin
                                    r_res   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_start <= w_start;
                                    r_end   <= w_end;
                                    if (w_unit) begin
                                        r_pos[FRAC_BITS-1:0] <= '0;
                                    end
                                    r_state <= S_CHK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    if (w_inside) begin
                        r_state <= S_RD0;
                    end else if (r_loop_en) begin
                        r_state <= S_MOD;
                    end else begin
                        r_playing  <= 1'b0;
                        r_finished <= 1'b1;
                        r_res      <= '0;
                        r_state    <= S_OUT;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_pos   <= w_ps + $signed(w_mod_rem);
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_nxt   <= w_nxt;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_s0w   <= w_ram_rdata;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pos   <= r_pos + POS_W'(r_rate);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res <= w_lane_res;
                    if (!w_inside) begin
                        r_pos <= (r_pos < w_ps) ? (r_pos + $signed(w_d))
                                                : (r_pos - $signed(w_d));
                        if (!r_loop_en) begin
                            r_playing  <= 1'b0;
                            r_finished <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid                <= 1'b1;
                        r_m_data                 <= r_res;
                        r_m_user[USER_ACTIVE]    <= r_playing;
                        r_m_user[USER_DONE]      <= r_finished;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/lsp_chk.sv
`default_nettype none

module lsp_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic [lsp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input wire logic [lsp_pkg::KIND_W-1:0]       i_s_tuser,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [lsp_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input wire logic [lsp_pkg::OUT_USER_W-1:0]   o_m_tuser,
    input wire logic                             i_cfg_valid,
    input wire logic                             o_cfg_ready,
    input wire logic [lsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input wire logic [lsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // playing and finished never report together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[USER_ACTIVE] && o_m_tuser[USER_DONE]))
        else $error("active and done both set");

    // no result appears in the cycle right after an accepted transaction while none was waiting
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result too early");

endmodule

bind looping_sample_player_interp lsp_chk u_lsp_chk (.*);

`default_nettype wire

>>> dv/tb_looping_sample_player_interp.sv
`timescale 1ns / 100ps

module tb_looping_sample_player_interp;
    import lsp_pkg::*;

    localparam longint UNIT_STEP    = longint'(1) << FRAC_BITS;
    // settle time covers an audible render with a modulo pass
    localparam int     SETTLE_CYC   = 64;
    // longest quiet stretch of a good run is the sink hold-off
    localparam int     STALL_LIMIT  = 4000;
    localparam int     HOLD_OFF_CYC = 300;
    localparam int     RANDOM_ITEMS = 1700;

    // one rendered frame as it leaves the block
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] ch0;
        logic signed [SAMPLE_BITS-1:0] ch1;
        logic                          active;
        logic                          done;
    } t_frame_out;

    // where the next render reads
    typedef struct {
        bit     audible;
        bit     in_region;
        longint pos;
        longint idx;
        longint nxt;
        longint frac;
        longint lo;
        longint hi;
    } t_read_plan;

    typedef enum {RX_OPEN, RX_CHOPPY} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [KIND_W-1:0]     i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // player state as the block should hold it
    logic [RAM_W-1:0]          smp_mem     [MAX_FRAMES];
    bit                        smp_written [MAX_FRAMES];
    logic signed [POS_W-1:0]   play_pos    = '0;
    logic                      playing     = 1'b0;
    logic                      finished    = 1'b0;
    logic [FRAME_W-1:0]        cfg_len     = '0;
    logic                      cfg_loop    = 1'b0;
    logic [FRAME_W-1:0]        cfg_lo      = '0;
    logic [FRAME_W-1:0]        cfg_hi      = '0;
    logic signed [RATE_W-1:0]  cfg_rate    = RATE_W'(UNIT_STEP);

    t_frame_out frames_due [$];

    int items_sent     = 0;
    int frames_checked = 0;
    int settings_run   = 0;
    int mismatches     = 0;

    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_hold_req  = 0;
    int       rx_hold_left = 0;
    int       rx_run_left  = 0;
    logic     rx_level     = 1'b1;

    looping_sample_player_interp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch: %s", msg);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand16();
        return ADDR_W'($urandom);
    endfunction

    function automatic longint sample_at(longint frame, int ch);
        logic [RAM_W-1:0]              word;
        logic signed [SAMPLE_BITS-1:0] v;
        word = smp_mem[frame];
        v = (ch != 0) ? word[2*SAMPLE_BITS-1:SAMPLE_BITS] : word[SAMPLE_BITS-1:0];
        return longint'(v);
    endfunction

    // region, unit-rate truncation and wrap for the next render
    function automatic t_read_plan plan_read();
        t_read_plan p;
        longint     len, e, ps, pe, d, r;
        p = '{default: 0};
        len = (cfg_len > MAX_FRAMES) ? MAX_FRAMES : longint'(cfg_len);
        p.audible = playing && len > 0 && cfg_rate != 0;
        if (p.audible) begin
            p.lo = 0;
            p.hi = len;
            if (cfg_loop && cfg_lo < cfg_hi) begin
                e = (longint'(cfg_hi) < len) ? longint'(cfg_hi) : len;
                if (longint'(cfg_lo) < e) begin
                    p.lo = longint'(cfg_lo);
                    p.hi = e;
                end
            end
            p.pos = longint'(play_pos);
            if (longint'(cfg_rate) == UNIT_STEP || longint'(cfg_rate) == -UNIT_STEP)
                p.pos = p.pos & ~(UNIT_STEP - 1);
            ps = p.lo * UNIT_STEP;
            pe = p.hi * UNIT_STEP;
            d  = pe - ps;
            p.in_region = 1'b1;
            if (p.pos < ps || p.pos >= pe) begin
                if (cfg_loop) begin
                    r = (p.pos - ps) % d;
                    if (r < 0)
                        r += d;
                    p.pos = ps + r;
                end else begin
                    p.in_region = 1'b0;
                end
            end
            p.idx  = p.pos >>> FRAC_BITS;
            p.frac = p.pos & (UNIT_STEP - 1);
            p.nxt  = p.idx + 1;
            if (p.nxt >= p.hi)
                p.nxt = cfg_loop ? p.lo : p.idx;
        end
        return p;
    endfunction

    // interpolate one frame and advance the position
    function automatic t_frame_out render_frame();
        t_read_plan p;
        t_frame_out f;
        longint     s0, s1, np, ps, pe;
        longint     res [2];
        p = plan_read();
        res[0] = 0;
        res[1] = 0;
        if (p.audible) begin
            if (p.in_region) begin
                for (int ch = 0; ch < 2; ch++) begin
                    s0 = sample_at(p.idx, ch);
                    s1 = sample_at(p.nxt, ch);
                    res[ch] = s0 + (((s1 - s0) * p.frac + (UNIT_STEP >>> 1)) >>> FRAC_BITS);
                end
                ps = p.lo * UNIT_STEP;
                pe = p.hi * UNIT_STEP;
                np = p.pos + longint'(cfg_rate);
                if (np < ps || np >= pe) begin
                    np += (np < ps) ? (pe - ps) : (ps - pe);
                    if (!cfg_loop) begin
                        playing  = 1'b0;
                        finished = 1'b1;
                    end
                end
            end else begin
                np       = p.pos;
                playing  = 1'b0;
                finished = 1'b1;
            end
            play_pos = np[POS_W-1:0];
        end
        f.ch0    = res[0][SAMPLE_BITS-1:0];
        f.ch1    = res[1][SAMPLE_BITS-1:0];
        f.active = playing;
        f.done   = finished;
        return f;
    endfunction

    function automatic void model_item(t_kind kind, logic [ADDR_W-1:0] addr,
                                       logic [SAMPLE_BITS-1:0] c0, logic [SAMPLE_BITS-1:0] c1);
        case (kind)
            KIND_LOAD: begin
                if (addr < MAX_FRAMES) begin
                    smp_mem[addr]     = {c1, c0};
                    smp_written[addr] = 1'b1;
                end
            end
            KIND_START: begin
                play_pos = '0;
                playing  = 1'b1;
                finished = 1'b0;
            end
            KIND_STOP: begin
                playing = 1'b0;
            end
            default: begin
                frames_due.push_back(render_frame());
            end
        endcase
    endfunction

    function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_BUF_LEN:    cfg_len  = val[FRAME_W-1:0];
            CFG_LOOP_EN:    cfg_loop = val[0];
            CFG_LOOP_START: cfg_lo   = val[FRAME_W-1:0];
            CFG_LOOP_END:   cfg_hi   = val[FRAME_W-1:0];
            CFG_RATE:       cfg_rate = val[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // one input transaction; valid stays high for a following item
    task automatic send_item(t_kind kind, logic [ADDR_W-1:0] addr,
                             logic [SAMPLE_BITS-1:0] c0, logic [SAMPLE_BITS-1:0] c1);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {c1, c0, addr};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        model_item(kind, addr, c0, c1);
    endtask

    // load any frame the render would read before it was written
    task automatic send_render();
        t_read_plan p;
        p = plan_read();
        if (p.audible && p.in_region) begin
            if (!smp_written[p.idx])
                send_item(KIND_LOAD, p.idx[ADDR_W-1:0], rand_sample(), rand_sample());
            if (!smp_written[p.nxt])
                send_item(KIND_LOAD, p.nxt[ADDR_W-1:0], rand_sample(), rand_sample());
        end
        send_item(KIND_RENDER, rand16(), rand_sample(), rand_sample());
    endtask

    task automatic sender_idle(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for every frame, then let the pipeline go quiet
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write all five registers back to back, only while idle
    task automatic apply_settings(logic [FRAME_W-1:0] len, logic loop_on,
                                  logic [FRAME_W-1:0] lo, logic [FRAME_W-1:0] hi,
                                  logic signed [RATE_W-1:0] rate);
        logic [CFG_IDX_W-1:0]  idx_list [5];
        logic [CFG_DATA_W-1:0] val_list [5];
        idx_list = '{CFG_BUF_LEN, CFG_LOOP_EN, CFG_LOOP_START, CFG_LOOP_END, CFG_RATE};
        val_list = '{CFG_DATA_W'(len), CFG_DATA_W'(loop_on), CFG_DATA_W'(lo),
                     CFG_DATA_W'(hi), CFG_DATA_W'(rate)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data  <= val_list[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            model_config(idx_list[i], val_list[i]);
        end
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // sink stall pattern and the long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else if (rx_mode == RX_OPEN) begin
            i_m_tready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_level    = ($urandom_range(0, 99) < 60);
                rx_run_left = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 14);
            end
            rx_run_left--;
            i_m_tready <= rx_level;
        end
    end

    // compare each output transaction with the oldest expected frame
    always @(posedge i_clk) begin : check_frames
        t_frame_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frames_due.size() == 0) begin
                report_mismatch($sformatf("frame with nothing expected: data %h user %b",
                                          o_m_tdata, o_m_tuser));
            end else begin
                want = frames_due.pop_front();
                if (o_m_tdata[SAMPLE_BITS-1:0] !== want.ch0)
                    report_mismatch($sformatf("frame %0d out_ch0 got %h want %h", frames_checked,
                                              o_m_tdata[SAMPLE_BITS-1:0], want.ch0));
                if (o_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.ch1)
                    report_mismatch($sformatf("frame %0d out_ch1 got %h want %h", frames_checked,
                                              o_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], want.ch1));
                if (o_m_tuser[USER_ACTIVE] !== want.active)
                    report_mismatch($sformatf("frame %0d active got %b want %b", frames_checked,
                                              o_m_tuser[USER_ACTIVE], want.active));
                if (o_m_tuser[USER_DONE] !== want.done)
                    report_mismatch($sformatf("frame %0d done_res got %b want %b", frames_checked,
                                              o_m_tuser[USER_DONE], want.done));
                frames_checked++;
            end
        end
    end

    // end the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // unit rate one-shot, extremes of the samples, silent before start and after finish
    task automatic test_oneshot_unit_rate();
        apply_settings(17'd3, 1'b0, 17'd0, 17'd0, RATE_W'(UNIT_STEP));
        send_item(KIND_LOAD, 16'd0, 16'h7FFF, 16'h8000);
        send_item(KIND_LOAD, 16'd1, 16'h8000, 16'h7FFF);
        send_item(KIND_LOAD, 16'd2, 16'h0000, 16'hFFFF);
        send_render();
        send_item(KIND_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) send_render();
        drain_results();
    endtask

    // half-step interpolation with rounding ties, start outside the loop region
    task automatic test_fractional_loop();
        apply_settings(17'd3, 1'b1, 17'd1, 17'd3, 24'sh008000);
        send_item(KIND_LOAD, 16'd1, 16'h0001, 16'hFFFF);
        send_item(KIND_LOAD, 16'd2, 16'h0000, 16'h7FFF);
        send_item(KIND_START, 16'h0000, 16'h0000, 16'h0000);
        repeat (4) send_render();
        drain_results();
    endtask

    // full buffer with extreme rate, empty region, zero length, negative unit rate
    task automatic test_region_extremes();
        apply_settings(MAX_LEN, 1'b1, MAX_LEN, MAX_LEN, 24'sh800000);
        send_item(KIND_START, rand16(), rand_sample(), rand_sample());
        repeat (2) send_render();
        send_item(KIND_STOP, rand16(), rand_sample(), rand_sample());
        send_render();
        drain_results();
        apply_settings(17'd0, 1'b0, 17'd5, 17'd2, 24'sd0);
        send_item(KIND_START, rand16(), rand_sample(), rand_sample());
        send_render();
        drain_results();
        apply_settings(17'd2, 1'b0, 17'd0, 17'd0, RATE_W'(-UNIT_STEP));
        send_item(KIND_START, rand16(), rand_sample(), rand_sample());
        repeat (2) send_render();
        drain_results();
    endtask

    // sink holds off while renders keep coming, then the sender waits for all frames
    task automatic test_backpressure();
        apply_settings(17'd16, 1'b1, 17'd0, 17'd16, 24'sd49152);
        rx_mode = RX_OPEN;
        send_item(KIND_START, rand16(), rand_sample(), rand_sample());
        rx_hold_req = HOLD_OFF_CYC;
        repeat (40) send_render();
        drain_results();
    endtask

    task automatic pick_settings();
        logic [FRAME_W-1:0]       len, lo, hi;
        logic signed [RATE_W-1:0] rate;
        int                       sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            len = '0;
        else if (sel == 1)
            len = MAX_LEN;
        else if (sel == 2)
            len = 17'd1;
        else
            len = FRAME_W'($urandom_range(2, 48));
        case ($urandom_range(0, 5))
            0: hi = MAX_LEN;
            1: hi = len;
            2: hi = '0;
            default: hi = FRAME_W'($urandom_range(0, int'(len) + 4));
        endcase
        case ($urandom_range(0, 3))
            0: lo = '0;
            1: lo = hi;
            default: lo = FRAME_W'($urandom_range(0, int'(hi)));
        endcase
        case ($urandom_range(0, 11))
            0: rate = RATE_W'(UNIT_STEP);
            1: rate = RATE_W'(-UNIT_STEP);
            2: rate = '0;
            3: rate = 24'sh7FFFFF;
            4: rate = 24'sh800000;
            5: rate = RATE_W'(UNIT_STEP / 2);
            6: rate = RATE_W'($urandom);
            default: rate = RATE_W'(longint'($urandom_range(0, 6 * UNIT_STEP)) - 3 * UNIT_STEP);
        endcase
        apply_settings(len, 1'($urandom_range(0, 1)), lo, hi, rate);
    endtask

    // random playback sessions: mostly start then renders, with loads, restarts and stops
    task automatic test_random_playback();
        int stop_at, n, burst_left, sel;
        bit gaps_on;
        logic [ADDR_W-1:0] addr;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            pick_settings();
            rx_mode    = ($urandom_range(0, 3) == 0) ? RX_OPEN : RX_CHOPPY;
            gaps_on    = ($urandom_range(0, 3) != 0);
            n          = $urandom_range(60, 140);
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 7) != 0)
                send_item(KIND_START, rand16(), rand_sample(), rand_sample());
            for (int k = 0; k < n; k++) begin
                if (burst_left == 0) begin
                    if (gaps_on)
                        sender_idle($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                sel = $urandom_range(0, 99);
                if (sel < 72) begin
                    send_render();
                end else if (sel < 86) begin
                    if (cfg_len != 0 && $urandom_range(0, 1))
                        addr = ADDR_W'($urandom_range(0, int'(cfg_len) - 1));
                    else
                        addr = rand16();
                    send_item(KIND_LOAD, addr, rand_sample(), rand_sample());
                end else if (sel < 94) begin
                    send_item(KIND_START, rand16(), rand_sample(), rand_sample());
                end else begin
                    send_item(KIND_STOP, rand16(), rand_sample(), rand_sample());
                end
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_oneshot_unit_rate();
        test_fractional_loop();
        test_region_extremes();
        test_backpressure();
        test_random_playback();
        drain_results();
        $display("run covered %0d input items and %0d checked frames over %0d register settings",
                 items_sent, frames_checked, settings_run);
        $display("including one-shot and looping regions, unit, fractional and extreme rates, "
                 , "and a %0d-cycle sink hold-off", HOLD_OFF_CYC);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
